/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the frequency-ranked cache.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

/* src/lfu_pkg.sv */
// Shared types and constants of the frequency-ranked cache.
// No dependencies; used by lfu_cmp and lfu_cache_lru_tiebreak.
package lfu_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int DATA_W       = 32;
    localparam int STAMP_W      = 64;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic key_hit;
        logic ranks_lower;
    } t_cmp_res;

endpackage

/* src/lfu_ram.sv */
// Entry store of the cache: one write port, one read port, registered read data.
// Depends on nothing; widths come from its parameters.
module lfu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 160
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lfu_cmp.sv */
// Shared compare unit: key match and (count, stamp) ranking of one entry.
// Depends on lfu_pkg for the entry and result types.
module lfu_cmp (
    input  logic [lfu_pkg::DATA_W-1:0]  i_key,
    input  lfu_pkg::t_entry             i_entry,
    input  logic [lfu_pkg::DATA_W-1:0]  i_best_count,
    input  logic [lfu_pkg::STAMP_W-1:0] i_best_stamp,
    output lfu_pkg::t_cmp_res           o_res
);

    // An entry ranks lower when it is used less often, or equally often but longer ago.
    always_comb begin
        o_res.key_hit     = (i_entry.key == i_key);
        o_res.ranks_lower = (i_entry.count < i_best_count) ||
                            ((i_entry.count == i_best_count) &&
                             (i_entry.stamp < i_best_stamp));
    end

endmodule

/* src/lfu_cache_lru_tiebreak.sv */
// Key-value cache with least-frequently-used replacement, oldest use breaking ties.
// Input channel: i_in_valid / i_in_data / o_in_stall; a beat is taken at a rising edge
// with valid high and stall low. Each beat is a get or a put of a key (and a value).
// Output channel: o_out_valid / o_out_data / i_out_stall, one result beat per input beat.
// Configuration: i_cfg_valid / i_cfg_data / o_cfg_ready writes the capacity register;
// ready is always high, and the register should only be written while the block is idle.
// Timing: after an input beat the sequencer scans every slot of the entry store, one slot
// per cycle through the single read port and the shared compare unit, looking at once for
// a key hit, the lowest-ranked victim, the first free slot and the number of used slots.
// The result is registered in the finishing step, and the next input beat is taken only
// once the sequencer is back in idle. The scan runs slot by slot because the entry store
// has only one read port.
// When the receiver stalls, the finished result waits in the output register; the next
// item is still taken and scanned, and only its final update waits until the output
// register is free.
// Reset (synchronous, active low) empties the cache, clears the use clock and sets the
// capacity to 16. No clearing pass is needed: per-slot valid bits live in flip-flops.
module lfu_cache_lru_tiebreak #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  lfu_pkg::t_in_item            i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output lfu_pkg::t_out_item           o_out_data,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_valid,
    input  logic [lfu_pkg::CAP_W-1:0]    i_cfg_data,
    output logic                         o_cfg_ready
);

    `include "assert_macros.svh"

    localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UsedW = $clog2(CAPACITY + 1);
    localparam int CmpW  = (UsedW > lfu_pkg::CAP_W) ? UsedW : lfu_pkg::CAP_W;
    localparam int EntW  = $bits(lfu_pkg::t_entry);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                         r_state;
    logic [lfu_pkg::CAP_W-1:0]      r_capacity;
    logic [CAPACITY-1:0]            r_valid;
    logic [lfu_pkg::STAMP_W-1:0]    r_clock;

    // Latched request.
    logic                           r_op;
    logic [lfu_pkg::DATA_W-1:0]     r_key;
    logic [lfu_pkg::DATA_W-1:0]     r_value;

    // Scan pointers: r_idx is the address being read, r_eidx the slot whose data is out.
    logic [IdxW-1:0]                r_idx;
    logic [IdxW-1:0]                r_eidx;
    logic                           r_pend;

    // Scan results.
    logic                           r_hit;
    logic [IdxW-1:0]                r_hit_idx;
    logic [lfu_pkg::DATA_W-1:0]     r_hit_val;
    logic [lfu_pkg::DATA_W-1:0]     r_hit_cnt;
    logic                           r_vic;
    logic [IdxW-1:0]                r_vic_idx;
    logic [lfu_pkg::DATA_W-1:0]     r_vic_key;
    logic [lfu_pkg::DATA_W-1:0]     r_vic_cnt;
    logic [lfu_pkg::STAMP_W-1:0]    r_vic_stamp;
    logic                           r_free;
    logic [IdxW-1:0]                r_free_idx;
    logic [UsedW-1:0]               r_used;

    logic                           r_out_valid;
    lfu_pkg::t_out_item             r_out;

    // Memory and compare unit hookup.
    logic [EntW-1:0]                w_rdata;
    lfu_pkg::t_entry                w_entry;
    lfu_pkg::t_cmp_res              w_cmp;
    logic                           w_we;
    logic [IdxW-1:0]                w_waddr;
    lfu_pkg::t_entry                w_wentry;

    // Finishing decisions.
    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_slot_valid;
    logic [CmpW-1:0]                w_cap_eff;
    logic                           w_cap_zero;
    logic                           w_full;
    logic                           w_evict;
    logic                           w_insert;
    logic [IdxW-1:0]                w_ins_idx;
    logic                           w_touch;
    logic [lfu_pkg::DATA_W-1:0]     w_hit_cnt_inc;

    assign w_entry = lfu_pkg::t_entry'(w_rdata);

    lfu_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EntW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (EntW'(w_wentry)),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    lfu_cmp u_cmp (
        .i_key        (r_key),
        .i_entry      (w_entry),
        .i_best_count (r_vic_cnt),
        .i_best_stamp (r_vic_stamp),
        .o_res        (w_cmp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_slot_valid = r_valid[r_eidx];

    // The effective capacity is the register value, capped at the physical slot count.
    always_comb begin
        if (CmpW'(r_capacity) > CmpW'(CAPACITY)) begin
            w_cap_eff = CmpW'(CAPACITY);
        end else begin
            w_cap_eff = CmpW'(r_capacity);
        end
    end

    assign w_cap_zero    = (r_capacity == '0);
    assign w_full        = (CmpW'(r_used) >= w_cap_eff);
    assign w_hit_cnt_inc = (r_hit_cnt == lfu_pkg::COUNT_MAX) ? r_hit_cnt
                                                             : r_hit_cnt + 1'b1;

    // A hit on a get, or on a put with a nonzero capacity, refreshes that entry.
    // A put of a new key evicts when the used slots reach the capacity, then inserts
    // into the first free slot or, failing that, into the victim's slot.
    always_comb begin
        w_touch   = r_hit && ((r_op == lfu_pkg::OP_GET) || !w_cap_zero);
        w_evict   = (r_op == lfu_pkg::OP_PUT) && !w_cap_zero && !r_hit && w_full && r_vic;
        w_insert  = (r_op == lfu_pkg::OP_PUT) && !w_cap_zero && !r_hit && (r_free || w_evict);
        w_ins_idx = r_free ? r_free_idx : r_vic_idx;

        w_wentry = '0;
        w_waddr  = r_hit_idx;
        if (w_touch) begin
            w_wentry.key   = r_key;
            w_wentry.value = (r_op == lfu_pkg::OP_PUT) ? r_value : r_hit_val;
            w_wentry.count = w_hit_cnt_inc;
            w_wentry.stamp = r_clock;
        end else begin
            w_waddr        = w_ins_idx;
            w_wentry.key   = r_key;
            w_wentry.value = r_value;
            w_wentry.count = lfu_pkg::DATA_W'(1);
            w_wentry.stamp = r_clock;
        end
        w_we = (r_state == S_FINISH) && w_out_free && (w_touch || w_insert);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_valid     <= '0;
            r_clock     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end

            // The finishing step reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            // Evaluate the slot whose data the memory presents this cycle.
            if (r_pend) begin
                if (w_slot_valid) begin
                    r_used <= r_used + UsedW'(1);
                    if (w_cmp.key_hit && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_eidx;
                        r_hit_val <= w_entry.value;
                        r_hit_cnt <= w_entry.count;
                    end
                    if (!r_vic || w_cmp.ranks_lower) begin
                        r_vic       <= 1'b1;
                        r_vic_idx   <= r_eidx;
                        r_vic_key   <= w_entry.key;
                        r_vic_cnt   <= w_entry.count;
                        r_vic_stamp <= w_entry.stamp;
                    end
                end else if (!r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_eidx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= i_in_data.operation;
                        r_key   <= i_in_data.key;
                        r_value <= i_in_data.value;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_vic   <= 1'b0;
                        r_free  <= 1'b0;
                        r_used  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= 1'b1;
                    r_eidx <= r_idx;
                    if (r_idx == LastIdx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IdxW'(1);
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        if (w_touch || w_insert) begin
                            r_clock <= r_clock + lfu_pkg::STAMP_W'(1);
                        end
                        // Without a free slot the new key reuses the victim's slot,
                        // which then simply stays valid.
                        if (w_evict && r_free) begin
                            r_valid[r_vic_idx] <= 1'b0;
                        end
                        if (w_insert) begin
                            r_valid[w_ins_idx] <= 1'b1;
                        end
                        r_out.found       <= r_hit;
                        r_out.read_value  <= (r_hit && (r_op == lfu_pkg::OP_GET)) ?
                                             r_hit_val : '0;
                        r_out.evicted     <= w_evict;
                        r_out.evicted_key <= w_evict ? r_vic_key : '0;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end else if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result beat only appears out of the finishing step.
    `ASSERT_NOW(a_out_from_finish, $rose(r_out_valid), $past(r_state == S_FINISH),
        "result appeared outside the finishing step")
    // A put of a new key with a nonzero capacity always has somewhere to go.
    `ASSERT_NOW(a_put_has_slot,
        (r_state == S_FINISH) && (r_op == lfu_pkg::OP_PUT) && !r_hit && !w_cap_zero,
        r_free || r_vic, "put of a new key found neither a free slot nor a victim")
    // The use clock advances by at most one per item.
    `ASSERT_NXT(a_clock_step, 1'b1,
        (r_clock == $past(r_clock)) || (r_clock == $past(r_clock) + lfu_pkg::STAMP_W'(1)),
        "use clock jumped")
    // The number of held entries grows by at most one per cycle.
    `ASSERT_NXT(a_fill_step, 1'b1, $countones(r_valid) <= $countones($past(r_valid)) + 1,
        "more than one entry filled at once")

endmodule
